[hdl/iir4x_pkg.sv]
// ----------------------------------------------------------------------------
// iir4x_pkg
// Shared types and constants of the 4x IIR interpolator: coefficient table,
// fixed-point constants and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package iir4x_pkg;

    // fractional bits of the coefficient table entries
    localparam int ROM_FRAC = 28;
    // guard bits carried by the section accumulator and state words
    localparam int GUARD = 8;
    localparam int ROM_ROWS = 4;
    localparam int ROM_COLS = 5;

    // butterworth sections at 0.2 of the rate, one row per section q
    // columns: b0, b1, b2, a1, a2 in Q3.28
    localparam logic signed [31:0] COEF_ROM [ROM_ROWS][ROM_COLS] = '{
        '{32'sd47983512, 32'sd95967024,  32'sd47983512, -32'sd85835515,  32'sd9334108},
        '{32'sd51788671, 32'sd103577342, 32'sd51788671, -32'sd92642391,  32'sd31361620},
        '{32'sd60679720, 32'sd121359440, 32'sd60679720, -32'sd108547183, 32'sd82830608},
        '{32'sd78227633, 32'sd156455266, 32'sd78227633, -32'sd139937844, 32'sd184412919}
    };

    // coefficient column select
    typedef enum logic [2:0] {
        C_B0 = 3'd0,
        C_B1 = 3'd1,
        C_B2 = 3'd2,
        C_A1 = 3'd3,
        C_A2 = 3'd4
    } coef_sel_t;

    // accumulator and state operations of one section step
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_Y       = 3'd1,
        OP_LOAD_S2 = 3'd2,
        OP_SUB     = 3'd3,
        OP_WR_S1   = 3'd4,
        OP_WR_S2   = 3'd5
    } acc_op_t;

    // source of a cascade pass input
    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_MID0 = 2'd1,
        SRC_MID1 = 2'd2
    } src_sel_t;

    typedef struct packed {
        logic      accept;
        logic      mul_en;
        coef_sel_t mul_coef;
        logic      mul_y;
        acc_op_t   op;
        logic      casc;
        logic      load_x;
        src_sel_t  src;
        logic      save_mid0;
        logic      save_mid1;
        logic      emit;
        logic      last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic out_valid;
    } dp_sts_t;

endpackage

[hdl/iir4x_ctrl.sv]
// ----------------------------------------------------------------------------
// iir4x_ctrl
// Sequencer of the interpolator: walks six cascade passes per input sample,
// the sections of each pass and the five multiply steps of each section.
// ----------------------------------------------------------------------------
module iir4x_ctrl #(
    parameter int SECTIONS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  iir4x_pkg::dp_sts_t   sts,
    output iir4x_pkg::dp_cmd_t   cmd,
    output logic [((SECTIONS > 1) ? $clog2(SECTIONS) : 1)-1:0] sec,
    output logic [((SECTIONS > 1) ? $clog2(SECTIONS) : 1)-1:0] mul_sec
);
    import iir4x_pkg::*;

    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTIONS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_END  = 3'b100
    } ctl_state_t;

    typedef enum logic [2:0] {
        STP_MUL_B0 = 3'd0,
        STP_Y      = 3'd1,
        STP_S2     = 3'd2,
        STP_SUB    = 3'd3,
        STP_WR_S1  = 3'd4,
        STP_WR_S2  = 3'd5
    } step_t;

    // first cascade: input and zero; second cascade: mid0, zero, mid1, zero
    typedef enum logic [2:0] {
        PASS_IN    = 3'd0,
        PASS_ZERO1 = 3'd1,
        PASS_MID0  = 3'd2,
        PASS_ZERO2 = 3'd3,
        PASS_MID1  = 3'd4,
        PASS_ZERO3 = 3'd5
    } pass_t;

    ctl_state_t       state_reg, state_next;
    step_t            step_reg, step_next;
    pass_t            pass_reg, pass_next;
    logic [SEC_W-1:0] sec_reg, sec_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STP_MUL_B0;
            pass_reg  <= PASS_IN;
            sec_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pass_reg  <= pass_next;
            sec_reg   <= sec_next;
        end
    end

    assign sec      = sec_reg;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        pass_next  = pass_reg;
        sec_next   = sec_reg;
        mul_sec    = sec_reg;
        cmd        = '0;
        cmd.casc   = (pass_reg != PASS_IN) && (pass_reg != PASS_ZERO1);

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    pass_next  = PASS_IN;
                    sec_next   = '0;
                    step_next  = STP_MUL_B0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                case (step_reg)
                    STP_MUL_B0: begin
                        cmd.mul_en   = 1'b1;
                        cmd.mul_coef = C_B0;
                        step_next    = STP_Y;
                    end
                    STP_Y: begin
                        cmd.op       = OP_Y;
                        cmd.mul_en   = 1'b1;
                        cmd.mul_coef = C_B1;
                        step_next    = STP_S2;
                    end
                    STP_S2: begin
                        cmd.op       = OP_LOAD_S2;
                        cmd.mul_en   = 1'b1;
                        cmd.mul_coef = C_A1;
                        cmd.mul_y    = 1'b1;
                        step_next    = STP_SUB;
                    end
                    STP_SUB: begin
                        cmd.op       = OP_SUB;
                        cmd.mul_en   = 1'b1;
                        cmd.mul_coef = C_B2;
                        step_next    = STP_WR_S1;
                    end
                    STP_WR_S1: begin
                        cmd.op       = OP_WR_S1;
                        cmd.mul_en   = 1'b1;
                        cmd.mul_coef = C_A2;
                        cmd.mul_y    = 1'b1;
                        step_next    = STP_WR_S2;
                    end
                    STP_WR_S2: begin
                        cmd.op = OP_WR_S2;
                        if (sec_reg == SEC_LAST) begin
                            state_next = ST_END;
                        end else begin
                            // start b0 of the next section on this section's output
                            cmd.mul_en   = 1'b1;
                            cmd.mul_coef = C_B0;
                            cmd.mul_y    = 1'b1;
                            mul_sec      = SEC_W'(sec_reg + 1'b1);
                            sec_next     = SEC_W'(sec_reg + 1'b1);
                            step_next    = STP_Y;
                        end
                    end
                    default: begin
                        step_next = STP_MUL_B0;
                    end
                endcase
            end
            ST_END: begin
                sec_next  = '0;
                step_next = STP_MUL_B0;
                case (pass_reg)
                    PASS_IN: begin
                        cmd.save_mid0 = 1'b1;
                        cmd.load_x    = 1'b1;
                        cmd.src       = SRC_ZERO;
                        pass_next     = PASS_ZERO1;
                        state_next    = ST_RUN;
                    end
                    PASS_ZERO1: begin
                        cmd.save_mid1 = 1'b1;
                        cmd.load_x    = 1'b1;
                        cmd.src       = SRC_MID0;
                        pass_next     = PASS_MID0;
                        state_next    = ST_RUN;
                    end
                    PASS_MID0: begin
                        if (sts.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.load_x = 1'b1;
                            cmd.src    = SRC_ZERO;
                            pass_next  = PASS_ZERO2;
                            state_next = ST_RUN;
                        end
                    end
                    PASS_ZERO2: begin
                        if (sts.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.load_x = 1'b1;
                            cmd.src    = SRC_MID1;
                            pass_next  = PASS_MID1;
                            state_next = ST_RUN;
                        end
                    end
                    PASS_MID1: begin
                        if (sts.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.load_x = 1'b1;
                            cmd.src    = SRC_ZERO;
                            pass_next  = PASS_ZERO3;
                            state_next = ST_RUN;
                        end
                    end
                    PASS_ZERO3: begin
                        if (sts.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            pass_next  = PASS_IN;
                            state_next = ST_IDLE;
                        end
                    end
                    default: begin
                        pass_next  = PASS_IN;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/iir4x_dp.sv]
// ----------------------------------------------------------------------------
// iir4x_dp
// Datapath of the interpolator: one shared multiplier with a product
// register, the section accumulator, the state words of both cascades, the
// pass input and midpoint registers and the output register.
// ----------------------------------------------------------------------------
module iir4x_dp #(
    parameter int SECTIONS    = 4,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  iir4x_pkg::dp_cmd_t            cmd,
    input  logic [((SECTIONS > 1) ? $clog2(SECTIONS) : 1)-1:0] sec,
    input  logic [((SECTIONS > 1) ? $clog2(SECTIONS) : 1)-1:0] mul_sec,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          out_ready,
    output iir4x_pkg::dp_sts_t            sts,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          last_out
);
    import iir4x_pkg::*;

    localparam int SEC_W      = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int COEF_FRAC  = COEF_BITS - 4;
    localparam int SIG_BITS   = SAMPLE_BITS + 4;
    localparam int STATE_BITS = SAMPLE_BITS + 16;
    localparam int ACC_BITS   = STATE_BITS + 2;
    localparam int PROD_BITS  = COEF_BITS + SIG_BITS;
    localparam int SH         = COEF_FRAC - GUARD;
    localparam logic signed [PROD_BITS-1:0] PROD_HALF = PROD_BITS'(1) << (SH - 1);
    localparam logic signed [ACC_BITS-1:0]  ACC_HALF  = ACC_BITS'(1) << (GUARD - 1);

    function automatic logic signed [SIG_BITS-1:0] sat_sig(
        input logic signed [ACC_BITS-1:0] v
    );
        logic [ACC_BITS-SIG_BITS:0] top;
        top = v[ACC_BITS-1:SIG_BITS-1];
        if ((top == '0) || (top == '1)) begin
            return v[SIG_BITS-1:0];
        end
        return v[ACC_BITS-1] ? {1'b1, {(SIG_BITS-1){1'b0}}} : {1'b0, {(SIG_BITS-1){1'b1}}};
    endfunction

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [ACC_BITS-1:0] v
    );
        logic [ACC_BITS-STATE_BITS:0] top;
        top = v[ACC_BITS-1:STATE_BITS-1];
        if ((top == '0) || (top == '1)) begin
            return v[STATE_BITS-1:0];
        end
        return v[ACC_BITS-1] ? {1'b1, {(STATE_BITS-1){1'b0}}}
                             : {1'b0, {(STATE_BITS-1){1'b1}}};
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
        input logic signed [ACC_BITS-1:0] v
    );
        logic [ACC_BITS-SAMPLE_BITS:0] top;
        top = v[ACC_BITS-1:SAMPLE_BITS-1];
        if ((top == '0) || (top == '1)) begin
            return v[SAMPLE_BITS-1:0];
        end
        return v[ACC_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                             : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

    logic signed [SIG_BITS-1:0]   x_reg, y_reg, mid0_reg, mid1_reg;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [ACC_BITS-1:0]   acc_reg;
    logic signed [STATE_BITS-1:0] s1_reg [2][SECTIONS];
    logic signed [STATE_BITS-1:0] s2_reg [2][SECTIONS];
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic                          last_reg, valid_reg;

    // coefficient from the table, scaled to COEF_FRAC fractional bits
    logic [1:0]                  coef_row;
    logic signed [63:0]          rom_w, coef_w;
    logic signed [COEF_BITS-1:0] coef;

    assign coef_row = 2'(mul_sec);
    assign rom_w    = 64'(COEF_ROM[coef_row][cmd.mul_coef]);

    generate
        if (COEF_FRAC >= ROM_FRAC) begin : g_coef_up
            assign coef_w = rom_w <<< (COEF_FRAC - ROM_FRAC);
        end else begin : g_coef_dn
            assign coef_w = (rom_w + (64'sd1 <<< (ROM_FRAC - COEF_FRAC - 1)))
                            >>> (ROM_FRAC - COEF_FRAC);
        end
    endgenerate

    assign coef = coef_w[COEF_BITS-1:0];

    logic signed [SIG_BITS-1:0]   mul_opnd;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [PROD_BITS-1:0]  prod_r;
    logic signed [STATE_BITS-1:0] rnd;
    logic signed [ACC_BITS-1:0]   rnd_w, s1_w, s2_w, y_sum, y_shr, s2_sum;
    logic signed [SIG_BITS-1:0]   src_val;

    assign mul_opnd = cmd.mul_y ? y_reg : x_reg;
    assign prod     = coef * mul_opnd;

    // product rounded half up back to state scale
    assign prod_r = prod_reg + PROD_HALF;
    assign rnd    = STATE_BITS'(prod_r >>> SH);
    assign rnd_w  = ACC_BITS'(rnd);
    assign s1_w   = ACC_BITS'(s1_reg[cmd.casc][sec]);
    assign s2_w   = ACC_BITS'(s2_reg[cmd.casc][sec]);
    assign y_sum  = rnd_w + s1_w + ACC_HALF;
    assign y_shr  = y_sum >>> GUARD;
    assign s2_sum = acc_reg - rnd_w;

    always_comb begin
        case (cmd.src)
            SRC_MID0: src_val = mid0_reg;
            SRC_MID1: src_val = mid1_reg;
            default:  src_val = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= prod;
        end
        if (cmd.accept) begin
            x_reg <= SIG_BITS'(sample_in) <<< 1;
        end else if (cmd.load_x) begin
            x_reg <= src_val;
        end else if (cmd.op == OP_WR_S2) begin
            x_reg <= y_reg;
        end
        if (cmd.op == OP_Y) begin
            y_reg <= sat_sig(y_shr);
        end
        case (cmd.op)
            OP_LOAD_S2: acc_reg <= rnd_w + s2_w;
            OP_SUB:     acc_reg <= acc_reg - rnd_w;
            OP_WR_S1:   acc_reg <= rnd_w;
            default:    acc_reg <= acc_reg;
        endcase
        if (cmd.save_mid0) begin
            mid0_reg <= sat_sig(ACC_BITS'(y_reg) <<< 1);
        end
        if (cmd.save_mid1) begin
            mid1_reg <= sat_sig(ACC_BITS'(y_reg) <<< 1);
        end
        if (cmd.emit) begin
            out_reg  <= sat_smp(ACC_BITS'(y_reg));
            last_reg <= cmd.last;
        end
    end

    // filter state words clear on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 2; c++) begin
                for (int k = 0; k < SECTIONS; k++) begin
                    s1_reg[c][k] <= '0;
                    s2_reg[c][k] <= '0;
                end
            end
        end else begin
            if (cmd.op == OP_WR_S1) begin
                s1_reg[cmd.casc][sec] <= sat_state(acc_reg);
            end
            if (cmd.op == OP_WR_S2) begin
                s2_reg[cmd.casc][sec] <= sat_state(s2_sum);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign sts.out_free  = !valid_reg || out_ready;
    assign sts.out_valid = valid_reg;
    assign sample_out    = out_reg;
    assign last_out      = last_reg;

endmodule

[hdl/iir_interpolator_4x.sv]
// ----------------------------------------------------------------------------
// iir_interpolator_4x
// 4x audio interpolator built from two cascades of butterworth biquads.
// ----------------------------------------------------------------------------
// Each base-rate sample transferred on the s_ channel gives four 4x-rate
// samples on the m_ channel, m_tlast high on the fourth. The input is doubled
// and zero-stuffed to 2x and filtered by a cascade of SECTIONS biquads, the
// result is doubled and zero-stuffed to 4x and filtered by a second cascade;
// outputs saturate to SAMPLE_BITS. All six cascade passes of an item run on a
// single shared multiplier, five multiplies per section; the passes that emit
// a result wait in their end state while the output register holds an untaken
// result. The next input is taken once the fourth result has been placed in
// the output register. Filter states clear on reset.
module iir_interpolator_4x #(
    parameter int SECTIONS    = 4,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [SAMPLE_BITS-1:0] sample_in
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [SAMPLE_BITS-1:0] sample_out
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata,
    output logic                                m_tlast
);
    import iir4x_pkg::*;

    localparam int SEC_W      = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    dp_cmd_t                  cmd;
    dp_sts_t                  sts;
    logic [SEC_W-1:0]         sec, mul_sec;
    logic signed [SAMPLE_BITS-1:0] sample_in, sample_out;

    assign sample_in = s_tdata[SAMPLE_BITS-1:0];

    iir4x_ctrl #(
        .SECTIONS (SECTIONS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd),
        .sec      (sec),
        .mul_sec  (mul_sec)
    );

    iir4x_dp #(
        .SECTIONS    (SECTIONS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sec        (sec),
        .mul_sec    (mul_sec),
        .sample_in  (sample_in),
        .out_ready  (m_tready),
        .sts        (sts),
        .sample_out (sample_out),
        .last_out   (m_tlast)
    );

    assign m_tvalid = sts.out_valid;
    assign m_tdata  = TDATA_BITS'($unsigned(sample_out));

endmodule
